### hdl/qpht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic probe hash table package
// Sizes, field widths and command/status codes shared by the hash table files.
// ----------------------------------------------------------------------------
package qpht_pkg;

	// Number of physical slots in the slot store.
	localparam int MAX_SLOTS = 1024;

	// Slot address width and the width of a count that can hold MAX_SLOTS itself.
	localparam int ADDR_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = ADDR_W + 1;

	// Fixed field widths of the request and response.
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 31;
	localparam int SIZE_W   = 11;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 10;
	localparam int OCC_W    = 11;

	// One slot entry: valid bit on top of the key.
	localparam int ENT_W = KEY_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	// Commands. Any other code acts as a search.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	// Response status codes.
	localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_MISSING = 2'd2;

endpackage
`default_nettype wire

### hdl/qpht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the address.
// ----------------------------------------------------------------------------
module qpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/quadratic_probe_hash_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic probe hash table unit
// Open-addressed key store with quadratic probing, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with a command (insert, delete,
//   search; code 3 searches) and a 31-bit key. Each request yields exactly one
//   response on rsp_valid/rsp_ready carrying status, slot_index and the
//   occupied slot count after the operation.
//   The table size register is written through cfg_we/cfg_wdata; the user
//   must do so only while the unit is idle, which the unit does not enforce.
//   A size of zero acts as one, sizes above the store act as the full store.
//   Sequence: the home slot (key mod size) is found by a bit-serial remainder
//   unit, then every probe passes a RAM read state and a check state with
//   optional write-back, then an output state moves the result to the
//   response register. A request visits n slots, n being between 1 and the
//   table size. The unit handles one request at a time and takes the next
//   one in the cycle after the result has left the core, even while a
//   response still waits.
//   Reset: after arst_n is released the slot store is cleared by a pass over
//   all 1024 slots, one slot per cycle, during which req_ready stays low.
//   Configuration writes are taken during that pass as well.
//   Stall: when rsp_ready is low the response holds; a finished second result
//   waits inside the unit until the response register frees up.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit
	import qpht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [SIZE_W-1:0]   cfg_wdata,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEY_W-1:0]    key,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [OCC_W-1:0]    occupied_count
);

	localparam int SUM_W   = CNT_W + 1;
	localparam int DCNT_W  = $clog2(KEY_W);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [SIZE_W-1:0]   table_size_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [CNT_W-1:0]    size_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    kshift_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic [ADDR_W-1:0]   probe_q;
	logic [CNT_W-1:0]    inc_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    occ_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_slot_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_index_q;
	logic [OCC_W-1:0]    occupied_count_q;

	logic [CNT_W-1:0]  eff_size;
	logic [SUM_W-1:0]  div_trial;
	logic [CNT_W-1:0]  rem_next;
	logic [SUM_W-1:0]  p_sum;
	logic [ADDR_W-1:0] p_next;
	logic [SUM_W-1:0]  inc_sum;
	logic [CNT_W-1:0]  inc_next;
	logic [CNT_W-1:0]  inc_first;
	logic              probe_last;
	logic              is_insert;
	logic              is_delete;
	logic              rd_valid;
	logic              key_match;
	logic              ins_here;
	logic              del_here;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ENT_W-1:0]  ram_rdata;
	logic              req_take;

	// Effective size: zero acts as one, oversize clamps to the slot store.
	always_comb begin
		if (table_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (32'(table_size_q) > 32'(MAX_SLOTS)) begin
			eff_size = CNT_W'(MAX_SLOTS);
		end else begin
			eff_size = CNT_W'(table_size_q);
		end
	end

	// One restoring remainder step per cycle, key bits taken MSB first.
	always_comb begin
		div_trial = {rem_q, kshift_q[KEY_W-1]};
		if (div_trial >= SUM_W'(size_q)) begin
			rem_next = CNT_W'(div_trial - SUM_W'(size_q));
		end else begin
			rem_next = CNT_W'(div_trial);
		end
	end

	// Next probe: (home + (i+1)^2) mod s = p + (2i+1) mod s. Both terms stay
	// below s, so one conditional subtract wraps the sum.
	always_comb begin
		p_sum = SUM_W'(probe_q) + SUM_W'(inc_q);
		if (p_sum >= SUM_W'(size_q)) begin
			p_next = ADDR_W'(p_sum - SUM_W'(size_q));
		end else begin
			p_next = ADDR_W'(p_sum);
		end
		inc_sum = SUM_W'(inc_q) + SUM_W'(2);
		if (size_q == CNT_W'(1)) begin
			inc_next = '0;
		end else if (inc_sum >= SUM_W'(size_q)) begin
			inc_next = CNT_W'(inc_sum - SUM_W'(size_q));
		end else begin
			inc_next = CNT_W'(inc_sum);
		end
		inc_first  = (size_q == CNT_W'(1)) ? CNT_W'(0) : CNT_W'(1);
		probe_last = (SUM_W'(idx_q) + SUM_W'(1)) == SUM_W'(size_q);
	end

	always_comb begin
		is_insert = (cmd_q == CMD_INSERT);
		is_delete = (cmd_q == CMD_DELETE);
		rd_valid  = ram_rdata[KEY_W];
		key_match = rd_valid && (ram_rdata[KEY_W-1:0] == key_q);
		ins_here  = is_insert && !rd_valid;
		del_here  = is_delete && key_match;
	end

	// Slot store port control: the clearing pass or the probe write-back.
	always_comb begin
		ram_we    = (state_q == ST_CLR) || ((state_q == ST_CHK) && (ins_here || del_here));
		ram_waddr = (state_q == ST_CLR) ? clr_q : probe_q;
		ram_wdata = ((state_q == ST_CHK) && ins_here) ? {1'b1, key_q} : '0;
	end

	qpht_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (probe_q),
		.rdata (ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			occ_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DCNT_W'(KEY_W - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (ins_here) begin
						occ_q   <= occ_q + CNT_W'(1);
						state_q <= ST_OUT;
					end else if (is_insert) begin
						state_q <= probe_last ? ST_OUT : ST_RD;
					end else if (!rd_valid || key_match) begin
						if (del_here && occ_q != '0) begin
							occ_q <= occ_q - CNT_W'(1);
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= probe_last ? ST_OUT : ST_RD;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request datapath: size latch, remainder unit, probe walk and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					cmd_q     <= command;
					key_q     <= key;
					kshift_q  <= key;
					size_q    <= eff_size;
					rem_q     <= '0;
					div_cnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q     <= rem_next;
				kshift_q  <= {kshift_q[KEY_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
				probe_q   <= ADDR_W'(rem_next);
				inc_q     <= inc_first;
				idx_q     <= '0;
			end
			ST_CHK: begin
				probe_q <= p_next;
				inc_q   <= inc_next;
				idx_q   <= idx_q + CNT_W'(1);
				if (ins_here || (!is_insert && key_match)) begin
					res_status_q <= STS_DONE;
					res_slot_q   <= probe_q;
				end else if (is_insert) begin
					res_status_q <= STS_FULL;
					res_slot_q   <= '0;
				end else begin
					res_status_q <= STS_MISSING;
					res_slot_q   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Response register; the core hands over once it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
			status_q         <= res_status_q;
			slot_index_q     <= SLOT_W'(res_slot_q);
			occupied_count_q <= OCC_W'(occ_q);
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign slot_index     = slot_index_q;
	assign occupied_count = occupied_count_q;

endmodule
`default_nettype wire

### tb/sv/tb_quadratic_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic probe hash table unit testbench
// Drives insert, delete and search requests through several table sizes and
// checks every response against a behavioral copy of the slot store.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table_unit
	import qpht_pkg::*;
();

	// Code 3 is not a named command; the unit treats it as a search.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	// Walks over a 1024-slot table, stalls and the clearing pass all fit well
	// inside this bound.
	localparam longint RUN_LIMIT_NS = 64'd200_000_000;

	// Largest number of keys remembered for hits on delete and search.
	localparam int KEY_POOL_MAX = 200;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [OCC_W-1:0]    occ;
	} hash_response_t;

	// Behavioral copy of the table. Each accepted request updates the copy
	// and queues the response that the unit owes for it.
	class hash_table_tracker;
		bit                  slot_used[MAX_SLOTS];
		logic [KEY_W-1:0]    slot_key[MAX_SLOTS];
		int                  occupancy;
		logic [SIZE_W-1:0]   table_size;
		hash_response_t      owed_q[$];
		int                  errors;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
			end
			occupancy  = 0;
			table_size = SIZE_RESET;
			errors     = 0;
		endfunction

		// A size of zero acts as one; anything above the store is clipped.
		function int span();
			if (table_size == 0)
				return 1;
			if (table_size > MAX_SLOTS)
				return MAX_SLOTS;
			return int'(table_size);
		endfunction

		function int probe_slot(int home, int step, int s);
			longint sq;
			sq = longint'(step) * longint'(step);
			return int'((longint'(home) + sq) % longint'(s));
		endfunction

		// Walks the probe sequence; stops at the first empty slot or match.
		function bit locate(logic [KEY_W-1:0] k, output int where);
			int s;
			int home;
			int p;
			s     = span();
			home  = int'(longint'(k) % longint'(s));
			where = 0;
			for (int i = 0; i < s; i++) begin
				p = probe_slot(home, i, s);
				if (!slot_used[p])
					return 1'b0;
				if (slot_key[p] == k) begin
					where = p;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
			hash_response_t r;
			int s;
			int home;
			int p;
			r.status = STS_MISSING;
			r.slot   = '0;
			if (cmd == CMD_INSERT) begin
				// Duplicates are not checked: the first empty probed slot wins.
				r.status = STS_FULL;
				s        = span();
				home     = int'(longint'(k) % longint'(s));
				for (int i = 0; i < s; i++) begin
					p = probe_slot(home, i, s);
					if (!slot_used[p]) begin
						slot_used[p] = 1'b1;
						slot_key[p]  = k;
						occupancy++;
						r.status = STS_DONE;
						r.slot   = SLOT_W'(p);
						break;
					end
				end
			end else if (cmd == CMD_DELETE) begin
				// No tombstone: the slot simply becomes empty again.
				if (locate(k, p)) begin
					slot_used[p] = 1'b0;
					slot_key[p]  = '0;
					if (occupancy > 0)
						occupancy--;
					r.status = STS_DONE;
					r.slot   = SLOT_W'(p);
				end
			end else if (locate(k, p)) begin
				r.status = STS_DONE;
				r.slot   = SLOT_W'(p);
			end
			r.occ = OCC_W'(occupancy);
			owed_q.push_back(r);
		endfunction

		function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
				logic [OCC_W-1:0] oc);
			hash_response_t want;
			if (owed_q.size() == 0) begin
				$error("response with none outstanding: status %0d slot_index %0d occupied_count %0d",
					st, sl, oc);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (sl !== want.slot) begin
				$error("slot_index: expected %0d, actual %0d", want.slot, sl);
				errors++;
			end
			if (oc !== want.occ) begin
				$error("occupied_count: expected %0d, actual %0d", want.occ, oc);
				errors++;
			end
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		function void close_out();
			if (owed_q.size() != 0) begin
				$error("%0d responses never arrived", owed_q.size());
				errors += owed_q.size();
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [SIZE_W-1:0]   cfg_wdata = '0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [CMD_W-1:0]    command = CMD_INSERT;
	logic [KEY_W-1:0]    key = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [OCC_W-1:0]    occupied_count;

	// Percentages of cycles in which the sender holds back and the
	// receiver refuses a response. Changed only while the unit is idle.
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;

	// Keys believed to be in the table, used to aim deletes and searches
	// at hits. It is only a hint; the tracker holds the real contents.
	logic [KEY_W-1:0] live_keys[$];

	hash_table_tracker tracker;

	quadratic_probe_hash_table_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.command       (command),
		.key           (key),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.slot_index    (slot_index),
		.occupied_count(occupied_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: a fresh ready decision every cycle.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Every response the unit hands over is checked against the oldest one
	// still owed. Values are sampled at the edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(status, slot_index, occupied_count);
	end

	// Presents one request and returns at the edge that accepts it, or after the
	// gap that follows. Valid is lowered only when a gap follows, so back-to-back requests keep it high.
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
		req_valid <= 1'b1;
		command   <= c;
		key       <= k;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		tracker.note_request(c, k);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Holds the sender back until every owed response has arrived. Each
	// request yields one response, so the unit is idle once the queue drains;
	// an extra wait follows anyway before anything else happens.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_table_size(input logic [SIZE_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.table_size = value;
	endtask

	// Random traffic: inserts of fresh, small and repeated keys, deletes and
	// searches mostly aimed at stored keys, and some aimed at nothing.
	task automatic random_traffic(input int count);
		int               roll;
		int               s;
		int               pick;
		logic [CMD_W-1:0] c;
		logic [KEY_W-1:0] k;
		for (int n = 0; n < count; n++) begin
			s    = tracker.span();
			roll = $urandom_range(99);
			if (roll < 40) begin
				c = CMD_INSERT;
				case ($urandom_range(3))
					0, 1: k = KEY_W'($urandom());
					2: k = KEY_W'($urandom_range(4 * s + 3));
					default: begin
						if (live_keys.size() != 0)
							k = live_keys[$urandom_range(live_keys.size() - 1)];
						else
							k = {KEY_W{1'b1}} - KEY_W'($urandom_range(s));
					end
				endcase
				live_keys.push_back(k);
				if (live_keys.size() > KEY_POOL_MAX)
					void'(live_keys.pop_front());
			end else if (roll < 80 && live_keys.size() != 0) begin
				pick = $urandom_range(live_keys.size() - 1);
				k    = live_keys[pick];
				if (roll < 58) begin
					c = CMD_DELETE;
					live_keys.delete(pick);
				end else if (roll < 75) begin
					c = CMD_SEARCH;
				end else begin
					c = CMD_SPARE;
				end
			end else begin
				case ($urandom_range(2))
					0: c = CMD_DELETE;
					1: c = CMD_SEARCH;
					default: c = CMD_SPARE;
				endcase
				if ($urandom_range(1) == 0)
					k = KEY_W'($urandom());
				else
					k = KEY_W'($urandom_range(4 * s + 3));
			end
			send_request(c, k);
		end
	endtask

	// Sets the handshake pressure for one of four modes: none, sender idle,
	// receiver stalling, both at a lighter rate.
	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 83;
				rsp_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				rsp_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 38;
				rsp_stall_pct = 38;
			end
		endcase
	endtask

	// Table sizes for the random phases: the extremes (zero, one, the full
	// store and the largest register value) among odd, even and prime sizes.
	// Keys from one phase stay put when the next one changes the size.
	int phase_sizes[15] = '{1024, 7, 2, 64, 0, 13, 2047, 3, 100, 16, 1, 31, 5, 1024, 8};

	initial begin
		int count;
		tracker = new();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting at the reset size of 1024. The largest key
		// lands in the last slot and key zero in the first.
		send_request(CMD_INSERT, {KEY_W{1'b1}});
		send_request(CMD_SEARCH, {KEY_W{1'b1}});
		send_request(CMD_INSERT, '0);
		send_request(CMD_SEARCH, '0);

		// With four slots, slot 3 cannot be reached from home 1 by squares,
		// so key 9 is refused although one slot is still empty.
		write_table_size(SIZE_W'(4));
		send_request(CMD_INSERT, KEY_W'(1));
		send_request(CMD_INSERT, KEY_W'(5));
		send_request(CMD_INSERT, KEY_W'(9));
		send_request(CMD_INSERT, KEY_W'(3));
		// Now every slot holds a key: a plain full table.
		send_request(CMD_INSERT, KEY_W'(2));
		// Missing keys after a walk over all probes.
		send_request(CMD_DELETE, KEY_W'(13));
		send_request(CMD_SEARCH, KEY_W'(17));
		// The unused command code searches.
		send_request(CMD_SPARE, KEY_W'(5));
		// Removing key 1 leaves a hole that hides key 5 from later searches.
		send_request(CMD_DELETE, KEY_W'(1));
		send_request(CMD_SEARCH, KEY_W'(5));
		// A duplicate insert takes the freed slot; the search finds the first copy.
		send_request(CMD_INSERT, '0);
		send_request(CMD_SEARCH, '0);
		send_request(CMD_DELETE, '0);
		send_request(CMD_DELETE, KEY_W'(3));

		// A size of zero behaves as a single slot.
		write_table_size('0);
		send_request(CMD_INSERT, KEY_W'(6));
		send_request(CMD_INSERT, KEY_W'(7));
		send_request(CMD_SEARCH, KEY_W'(6));
		send_request(CMD_DELETE, KEY_W'(6));

		// The largest register value is clipped to the full store, and the
		// key parked in the last slot is visible again.
		write_table_size({SIZE_W{1'b1}});
		send_request(CMD_SEARCH, {KEY_W{1'b1}});
		send_request(CMD_SEARCH, KEY_W'(MAX_SLOTS));

		// Random phases. Large tables get fewer requests since their walks
		// can run long. Some phases also pause halfway until the unit drains.
		foreach (phase_sizes[ph]) begin
			write_table_size(SIZE_W'(phase_sizes[ph]));
			set_idle_mode(ph % 4);
			count = (phase_sizes[ph] >= MAX_SLOTS) ? 60 : 114;
			random_traffic(count / 2);
			if (ph % 3 == 1)
				wait_idle();
			random_traffic(count - count / 2);
		end

		wait_idle();
		repeat (100)
			@(posedge clk);
		tracker.close_out();
		if (tracker.errors == 0)
			$display("tb_quadratic_probe_hash_table_unit: done, clean");
		else
			$display("tb_quadratic_probe_hash_table_unit: done, errors");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_quadratic_probe_hash_table_unit: done, errors");
		$finish;
	end

endmodule

### quadratic_probe_hash_table_unit.f
hdl/qpht_pkg.sv
hdl/qpht_ram.sv
hdl/quadratic_probe_hash_table_unit.sv
tb/sv/tb_quadratic_probe_hash_table_unit.sv
